FILE: design/temporal_stream_branch_predictor_top_assert.svh
// Assertion macros used by the predictor's sequencer, tsbp_ctrl.
`ifndef TEMPORAL_STREAM_BRANCH_PREDICTOR_TOP_ASSERT_SVH
`define TEMPORAL_STREAM_BRANCH_PREDICTOR_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TSBP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tsbp check failed");

// Consequent checked in the cycle after the antecedent.
`define TSBP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tsbp check failed");

`endif

FILE: design/tsbp_pkg.sv
// Shared types and constants of the branch predictor.
`default_nettype none
package tsbp_pkg;
  localparam int HIST_W      = 34;
  localparam int PC_KEY_BITS = 30;
  localparam int KEY_W       = HIST_W + PC_KEY_BITS;
  localparam int STAMP_W     = 16;
  localparam logic [31:0] INSN_BYTES = 32'd4;

  typedef struct packed {
    logic clear;   // clearing pass step
    logic accept;  // take item, launch memory reads
    logic commit;  // finish item, write back / load result
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic is_update;
  } status_t;
endpackage
`default_nettype wire

FILE: design/tsbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module tsbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic                                 re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

FILE: design/tsbp_ctrl.sv
// Sequencer: clearing pass, item acceptance, commit and result handshake.
`default_nettype none
`include "temporal_stream_branch_predictor_top_assert.svh"
module tsbp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  output logic                  out_valid,
  input  wire logic             out_stall,
  input  wire tsbp_pkg::status_t st,
  output tsbp_pkg::cmd_t        cmd
);
  import tsbp_pkg::*;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;
  state_t state;

  always_comb begin
    in_stall   = (state != S_IDLE);
    cmd.clear  = (state == S_CLEAR);
    cmd.accept = (state == S_IDLE) && in_valid;
    cmd.commit = (state == S_EXEC) && (st.is_update || !out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_CLEAR: if (st.clear_done) state <= S_IDLE;
        S_IDLE:  if (in_valid) state <= S_EXEC;
        S_EXEC:  if (cmd.commit) state <= S_IDLE;
        default: state <= S_CLEAR;
      endcase
      if (cmd.commit && !st.is_update) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  `TSBP_ASSERT_NEXT(a_accept_to_exec, cmd.accept, state == S_EXEC)
  `TSBP_ASSERT_NEXT(a_predict_result, cmd.commit && !st.is_update, out_valid)
  `TSBP_ASSERT_NEXT(a_update_silent, cmd.commit && st.is_update && !out_valid, !out_valid)
  `TSBP_ASSERT_NOW(a_clear_quiet, state == S_CLEAR, !out_valid && !cmd.commit)
endmodule
`default_nettype wire

FILE: design/tsbp_dp.sv
// Datapath: target cache, head cache, stream log and predictor registers.
`default_nettype none
module tsbp_dp #(
  parameter int LOG_LENGTH = 1024,
  parameter int WAYS       = 4,
  parameter int SET_BITS   = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tsbp_pkg::cmd_t cmd,
  output tsbp_pkg::status_t  st,
  input  wire logic          mode,
  input  wire logic [31:0]   pc,
  input  wire logic [31:0]   next_pc,
  input  wire logic          was_mispredicted,
  input  wire logic          is_branch,
  output logic      [31:0]   pred_target,
  output logic               pred_taken
);
  import tsbp_pkg::*;

  localparam int SETS  = 1 << SET_BITS;
  localparam int LOG_W = $clog2(LOG_LENGTH);
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int CLR_N = (SETS > LOG_LENGTH) ? SETS : LOG_LENGTH;
  localparam int CLR_W = $clog2(CLR_N);
  localparam int HD_W  = 1 + KEY_W + STAMP_W + LOG_W;
  localparam logic [CLR_W-1:0]   CLR_LAST = CLR_W'(CLR_N - 1);
  localparam logic [CLR_W:0]     SETS_C   = (CLR_W + 1)'(SETS);
  localparam logic [CLR_W:0]     LOG_C    = (CLR_W + 1)'(LOG_LENGTH);
  localparam logic [WAY_W-1:0]   WAY_LAST = WAY_W'(WAYS - 1);
  localparam logic [LOG_W-1:0]   LOG_LAST = LOG_W'(LOG_LENGTH - 1);
  localparam logic [STAMP_W-1:0] LOG_LEN_S = STAMP_W'(LOG_LENGTH);

  // latched item
  logic        mode_r, br_r, mis_r;
  logic [31:0] pc_r, npc_r;

  // predictor state
  logic [HIST_W-1:0]  hist;
  logic [STAMP_W-1:0] ws;
  logic [LOG_W-1:0]   ws_mod;
  logic [LOG_W-1:0]   rp;
  logic               ra;
  logic [WAY_W-1:0]   tv, hv;
  logic [CLR_W-1:0]   clr_cnt;

  // memory read data
  logic [31:0]        t_tag   [WAYS];
  logic [31:0]        t_val   [WAYS];
  logic               h_valid [WAYS];
  logic [KEY_W-1:0]   h_key   [WAYS];
  logic [STAMP_W-1:0] h_stamp [WAYS];
  logic [LOG_W-1:0]   h_smod  [WAYS];
  logic               log_q;

  // combinational results
  logic               outcome, upd, pred_go, taken;
  logic               t_any, e_any, h_any, s_any;
  logic [WAY_W-1:0]   t_sel, e_sel, h_sel, s_sel, t_slot, h_slot, tv_inc, hv_inc;
  logic [HIST_W-1:0]  hist_new;
  logic [STAMP_W-1:0] ws_new;
  logic [LOG_W-1:0]   ws_mod_new;
  logic [KEY_W-1:0]   key;
  logic               t_we, h_we, clr_set, clr_log;
  logic [31:0]        target;

  assign st.clear_done = (clr_cnt == CLR_LAST);
  assign st.is_update  = mode_r;

  assign clr_set = cmd.clear && ({1'b0, clr_cnt} < SETS_C);
  assign clr_log = cmd.clear && ({1'b0, clr_cnt} < LOG_C);

  always_comb begin
    upd        = cmd.commit && mode_r && br_r;
    pred_go    = cmd.commit && !mode_r;
    outcome    = (pc_r + INSN_BYTES) != npc_r;
    hist_new   = {hist[HIST_W-2:0], outcome};
    key        = {hist_new, pc_r[31:2]};
    ws_new     = ws + 1'b1;
    ws_mod_new = (ws == '1 || ws_mod == LOG_LAST) ? '0 : ws_mod + 1'b1;
    tv_inc     = (tv == WAY_LAST) ? '0 : tv + 1'b1;
    hv_inc     = (hv == WAY_LAST) ? '0 : hv + 1'b1;
    t_any = 1'b0; t_sel = '0;
    e_any = 1'b0; e_sel = '0;
    h_any = 1'b0; h_sel = '0;
    s_any = 1'b0; s_sel = '0;
    // descending scan leaves the lowest matching way selected
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (t_tag[w] == pc_r) begin
        t_any = 1'b1; t_sel = WAY_W'(w);
      end
      if (t_tag[w] == '0) begin
        e_any = 1'b1; e_sel = WAY_W'(w);
      end
      if (h_valid[w] && (STAMP_W'(ws_new - h_stamp[w]) < LOG_LEN_S)) begin
        if (h_key[w] == key) begin
          h_any = 1'b1; h_sel = WAY_W'(w);
        end
      end else begin
        s_any = 1'b1; s_sel = WAY_W'(w);
      end
    end
    t_slot = t_any ? t_sel : (e_any ? e_sel : tv_inc);
    h_slot = h_any ? h_sel : (s_any ? s_sel : hv_inc);
    t_we   = upd && outcome;
    h_we   = upd && !outcome;
    taken  = !(ra && !log_q);
    target = (taken && t_any) ? t_val[t_sel] : '0;
  end

  for (genvar w = 0; w < WAYS; w++) begin : g_way
    logic [63:0]     t_q;
    logic [HD_W-1:0] h_q;

    tsbp_ram #(.WIDTH(64), .DEPTH(SETS)) u_tram (
      .clk   (clk),
      .we    (clr_set || (t_we && t_slot == WAY_W'(w))),
      .waddr (cmd.clear ? clr_cnt[SET_BITS-1:0] : pc_r[SET_BITS-1:0]),
      .wdata (cmd.clear ? 64'd0 : {pc_r, npc_r}),
      .re    (cmd.accept),
      .raddr (pc[SET_BITS-1:0]),
      .rdata (t_q)
    );

    tsbp_ram #(.WIDTH(HD_W), .DEPTH(SETS)) u_hram (
      .clk   (clk),
      .we    (clr_set || (h_we && h_slot == WAY_W'(w))),
      .waddr (cmd.clear ? clr_cnt[SET_BITS-1:0] : pc_r[SET_BITS+1:2]),
      .wdata (cmd.clear ? '0 : {1'b1, key, ws_new, ws_mod_new}),
      .re    (cmd.accept),
      .raddr (pc[SET_BITS+1:2]),
      .rdata (h_q)
    );

    assign t_tag[w]   = t_q[63:32];
    assign t_val[w]   = t_q[31:0];
    assign h_valid[w] = h_q[HD_W-1];
    assign h_key[w]   = h_q[HD_W-2 -: KEY_W];
    assign h_stamp[w] = h_q[LOG_W +: STAMP_W];
    assign h_smod[w]  = h_q[LOG_W-1:0];
  end

  tsbp_ram #(.WIDTH(1), .DEPTH(LOG_LENGTH)) u_log (
    .clk   (clk),
    .we    (clr_log || upd),
    .waddr (cmd.clear ? clr_cnt[LOG_W-1:0] : ws_mod),
    .wdata (!cmd.clear && outcome),
    .re    (cmd.accept),
    .raddr (rp),
    .rdata (log_q)
  );

  // latch item and result payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r <= mode;
      pc_r   <= pc;
      npc_r  <= next_pc;
      mis_r  <= was_mispredicted;
      br_r   <= is_branch;
    end
    if (pred_go) begin
      pred_target <= target;
      pred_taken  <= (target != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      ws      <= LOG_LEN_S;
      ws_mod  <= '0;
      rp      <= '0;
      ra      <= 1'b0;
      tv      <= '0;
      hv      <= '0;
      clr_cnt <= '0;
    end else begin
      if (cmd.clear && !st.clear_done) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (pred_go && ra) begin
        rp <= (rp == LOG_LAST) ? '0 : rp + 1'b1;
      end
      if (upd) begin
        hist   <= hist_new;
        ws     <= ws_new;
        ws_mod <= ws_mod_new;
        if (t_we && !t_any && !e_any) begin
          tv <= tv_inc;
        end
        if (h_we && h_any) begin
          rp <= h_smod[h_sel];
          ra <= 1'b1;
        end else if (mis_r) begin
          ra <= 1'b0;
        end
        if (h_we && !h_any && !s_any) begin
          hv <= hv_inc;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: design/temporal_stream_branch_predictor_top.sv
// Top level of the temporal-stream branch target predictor.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  input   | in_valid / in_stall  | mode, pc, next_pc, was_mispredicted, is_branch
//  output  | out_valid / out_stall| pred_target, pred_taken
//
// For each item the accept cycle launches the synchronous reads of the target,
// head and log memories; the evaluation state then evaluates and writes back.
// A predict item yields one result; an update item yields none.
// After reset a clearing pass zeroes every row of the memories, one row per
// cycle, with in_stall held high.
// A pending result waits in the output register; a new item is taken meanwhile,
// and a predict only holds in evaluation while an older result is stalled.
`default_nettype none
module temporal_stream_branch_predictor_top #(
  parameter int LOG_LENGTH = 1024,
  parameter int WAYS       = 4,
  parameter int SET_BITS   = 10
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [31:0] pc,
  input  wire logic [31:0] next_pc,
  input  wire logic        was_mispredicted,
  input  wire logic        is_branch,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [31:0] pred_target,
  output logic             pred_taken
);
  import tsbp_pkg::*;

  cmd_t    cmd;
  status_t st;

  // sequence items: clear, accept, commit
  tsbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  // hold caches, log, history and replay state
  tsbp_dp #(
    .LOG_LENGTH (LOG_LENGTH),
    .WAYS       (WAYS),
    .SET_BITS   (SET_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .st               (st),
    .mode             (mode),
    .pc               (pc),
    .next_pc          (next_pc),
    .was_mispredicted (was_mispredicted),
    .is_branch        (is_branch),
    .pred_target      (pred_target),
    .pred_taken       (pred_taken)
  );
endmodule
`default_nettype wire
